// ===== rtl/mrq_pkg.sv =====
// Shared constants, types and codes of the multilevel ready queue.
`timescale 1ns / 1ps
package mrq_pkg;

  localparam int LEVELS    = 16;
  localparam int DEPTH     = 8;
  localparam int TASK_BITS = 8;

  localparam int LEVEL_W  = $clog2(LEVELS);
  localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int META_W   = PTR_W + CNT_W;
  localparam int TS_WORDS = LEVELS * DEPTH;
  localparam int TS_AW    = $clog2(TS_WORDS);

  localparam int MODE_W   = 2;
  localparam int TASK_W   = 8;
  localparam int LVL_IN_W = 4;
  localparam int STAT_W   = 2;
  localparam int CAP_W    = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_PUSH   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_HEAD_META,
    ST_HEAD_TASK,
    ST_RESULT
  } state_t;

endpackage

// ===== rtl/mrq_if.sv =====
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps
interface mrq_req_if;
  import mrq_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [TASK_W-1:0]   task_id;
  logic [LVL_IN_W-1:0] level;
  modport source (output valid, mode, task_id, level, input ready);
  modport sink   (input valid, mode, task_id, level, output ready);
endinterface

interface mrq_rsp_if;
  import mrq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [TASK_W-1:0]   head_task;
  logic                head_valid;
  logic [LVL_IN_W-1:0] top_level;
  modport source (output valid, status, head_task, head_valid, top_level, input ready);
  modport sink   (input valid, status, head_task, head_valid, top_level, output ready);
endinterface

interface mrq_cfg_if;
  import mrq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/mrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int WORDS = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/multilevel_ready_queue.sv =====
// Multilevel ready queue: one FIFO of task ids per priority level, level 0 most urgent.
// Each request appends a task at the tail of its level, pushes it at the head, or
// removes the head of the most urgent nonempty level; each gives one response with a
// status and the head task afterwards. The response is offered after these steps in
// order: the level descriptor is read at the accepting edge, then come the update and
// task write, the head descriptor read, the head task read and the response load. The
// next request is accepted in the cycle after the response register loads, so no new
// request is taken while one is in progress; a response not yet taken holds the
// following request in its last step. This spacing is set by the single read port of
// the descriptor memory and of the task memory, visited in turn. Level descriptors
// read as empty until first written, so no clearing pass follows reset.
`timescale 1ns / 1ps
module multilevel_ready_queue
  import mrq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mrq_req_if.sink     req,
  mrq_rsp_if.source   rsp,
  mrq_cfg_if.sink     cfg
);

  state_t state, state_next;

  logic [CAP_W-1:0]   level_capacity;
  logic [LEVELS-1:0]  nonempty, nonempty_next;
  logic [LEVELS-1:0]  meta_vld;
  logic               meta_rd_vld;

  mode_t              op_mode;
  logic [TASK_W-1:0]  op_task;
  logic [LEVEL_W-1:0] op_lvl;
  logic               op_in_range;
  status_t            op_status, op_status_next;
  logic [LEVEL_W-1:0] top_q;

  logic               meta_we;
  logic [LEVEL_W-1:0] meta_raddr;
  logic [META_W-1:0]  meta_wdata, meta_rdata;
  logic               ts_we;
  logic [TS_AW-1:0]   ts_waddr, ts_raddr;
  logic [TASK_BITS-1:0] ts_wdata, ts_rdata;

  logic [PTR_W-1:0]   hp, hp_new, slot;
  logic [CNT_W-1:0]   cnt, cnt_new;
  logic [LEVEL_W-1:0] top_now;
  logic               full;
  int                 tail_sum;

  function automatic logic [LEVEL_W-1:0] first_set(input logic [LEVELS-1:0] v);
    logic [LEVEL_W-1:0] r;
    r = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (v[i]) r = LEVEL_W'(i);
    end
    return r;
  endfunction

  mrq_ram #(.WIDTH(META_W), .WORDS(LEVELS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (op_lvl),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  mrq_ram #(.WIDTH(TASK_BITS), .WORDS(TS_WORDS)) u_task_ram (
    .clk   (clk),
    .we    (ts_we),
    .waddr (ts_waddr),
    .wdata (ts_wdata),
    .raddr (ts_raddr),
    .rdata (ts_rdata)
  );

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign top_now   = first_set(nonempty);

  always_comb begin
    hp = meta_rd_vld ? meta_rdata[META_W-1:CNT_W] : '0;
    cnt = meta_rd_vld ? meta_rdata[CNT_W-1:0] : '0;
  end

  always_comb begin
    state_next     = state;
    nonempty_next  = nonempty;
    op_status_next = op_status;
    meta_we        = 1'b0;
    ts_we          = 1'b0;
    hp_new         = hp;
    cnt_new        = cnt;
    slot           = hp;
    tail_sum       = 32'(hp) + 32'(cnt);
    full           = !op_in_range || (32'(cnt) >= 32'(level_capacity)) || (32'(cnt) >= DEPTH);
    meta_raddr     = top_now;
    ts_raddr       = TS_AW'(32'(top_q) * DEPTH + 32'(hp));
    if (tail_sum >= DEPTH) tail_sum = tail_sum - DEPTH;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (mode_t'(req.mode) != MODE_REMOVE) meta_raddr = LEVEL_W'(req.level);
          state_next = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        op_status_next = STAT_OK;
        case (op_mode)
          MODE_APPEND, MODE_PUSH: begin
            if (full) begin
              op_status_next = STAT_FULL;
            end else begin
              if (op_mode == MODE_APPEND) begin
                slot = PTR_W'(tail_sum);
              end else begin
                slot   = (hp == '0) ? PTR_W'(DEPTH - 1) : hp - 1'b1;
                hp_new = slot;
              end
              cnt_new = cnt + 1'b1;
              meta_we = 1'b1;
              ts_we   = 1'b1;
              nonempty_next[op_lvl] = 1'b1;
            end
          end
          MODE_REMOVE: begin
            if (nonempty == '0) begin
              op_status_next = STAT_EMPTY;
            end else begin
              hp_new  = (32'(hp) == DEPTH - 1) ? '0 : hp + 1'b1;
              cnt_new = cnt - 1'b1;
              meta_we = 1'b1;
              if (cnt_new == '0) nonempty_next[op_lvl] = 1'b0;
            end
          end
          default: ;
        endcase
        state_next = ST_HEAD_META;
      end
      ST_HEAD_META: state_next = ST_HEAD_TASK;
      ST_HEAD_TASK: state_next = ST_RESULT;
      ST_RESULT: begin
        if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    meta_wdata = {hp_new, cnt_new};
  end

  assign ts_waddr = TS_AW'(32'(op_lvl) * DEPTH + 32'(slot));
  assign ts_wdata = TASK_BITS'(op_task);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      level_capacity <= CAP_RESET;
      nonempty       <= '0;
      meta_vld       <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      state    <= state_next;
      nonempty <= nonempty_next;
      if (cfg.valid) level_capacity <= cfg.data;
      if (meta_we) meta_vld[op_lvl] <= 1'b1;
      if (state == ST_RESULT && state_next == ST_IDLE) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    meta_rd_vld <= meta_vld[meta_raddr];
    op_status   <= op_status_next;
    if (state == ST_IDLE && req.valid) begin
      op_mode     <= mode_t'(req.mode);
      op_task     <= req.task_id;
      op_in_range <= (32'(req.level) < LEVELS);
      op_lvl      <= (mode_t'(req.mode) == MODE_REMOVE) ? top_now : LEVEL_W'(req.level);
    end
    if (state == ST_HEAD_META) top_q <= top_now;
    if (state == ST_RESULT && state_next == ST_IDLE) begin
      rsp.status     <= op_status;
      rsp.head_valid <= (nonempty != '0);
      rsp.head_task  <= (nonempty != '0) ? TASK_W'(ts_rdata) : '0;
      rsp.top_level  <= (nonempty != '0) ? LVL_IN_W'(top_q) : '0;
    end
  end

endmodule
